>>> hw/rtl/csbf_pkg.sv
// shared types and constants of the cascaded shelf biquad filter
// used by the top level and the testbench

package csbf_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int GAIN_BITS = 18;
  localparam int GAIN_FRAC = 17;
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 18'd131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYPASS      = 3'd0,
    REG_LOW_NUM     = 3'd1,
    REG_LOW_DEN     = 3'd2,
    REG_HIGH_NUM    = 3'd3,
    REG_HIGH_DEN    = 3'd4,
    REG_OUTPUT_GAIN = 3'd5
  } csbf_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_FIN,
    ST_GAIN,
    ST_OUT
  } csbf_state_e;

endpackage

>>> hw/rtl/cascaded_shelf_biquad_filter.sv
// two cascaded shelf biquads (low, then high) with output gain, on one shared multiplier
// depends on csbf_pkg
// filtering: a new item is taken only after the last result enters the output register,
//   with the single multiplier doing five products per section plus one for the gain
// bypass: the sample is loaded unchanged into the output register, one item at a time
// reset: bypass on, coefficients zero, unity gain, all state words zero, no result pending

module cascaded_shelf_biquad_filter #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 20,
  parameter int STATE_WIDTH  = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csbf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [3*COEF_WIDTH-1:0]           cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  output logic                              overflow_reset_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int STW = STATE_WIDTH;
  localparam int SAF = SW - 1;
  localparam int CF  = CW - 3;
  localparam int SF  = STW - 9;
  localparam int PF  = SAF + CF;

  // product to state alignment
  localparam int RS1 = (PF > SF) ? PF - SF : 0;
  localparam int LS1 = (SF > PF) ? SF - PF : 0;
  localparam int H1  = (RS1 > 0) ? RS1 - 1 : 0;
  // state to sample alignment
  localparam int RS2 = (SF > SAF) ? SF - SAF : 0;
  localparam int LS2 = (SAF > SF) ? SAF - SF : 0;
  localparam int H2  = (RS2 > 0) ? RS2 - 1 : 0;

  // growth of the section output through both sections
  localparam int A1W = SW + CW + 1 - RS1 + LS1;
  localparam int Y1W = ((A1W > STW) ? A1W : STW) + 1;
  localparam int YW1 = Y1W + 1 - RS2 + LS2;
  localparam int A2W = YW1 + CW + 1 - RS1 + LS1;
  localparam int Y2W = ((A2W > STW) ? A2W : STW) + 1;
  localparam int DW  = Y2W + 1 - RS2 + LS2;

  localparam int KW  = (CW > csbf_pkg::GAIN_BITS) ? CW : csbf_pkg::GAIN_BITS + 1;
  localparam int PW  = KW + DW;
  localparam int EW  = PW + 1;
  localparam int TW1 = EW + 1;
  localparam int AW  = TW1 - RS1 + LS1;
  localparam int NW  = ((AW > STW) ? AW : STW) + 1;
  localparam int GW  = PW + 1;
  localparam int GF  = csbf_pkg::GAIN_FRAC;

  localparam logic signed [TW1-1:0] HALF1 = TW1'(RS1 > 0) << H1;
  localparam logic signed [NW:0]    HALF2 = (NW + 1)'(RS2 > 0) << H2;
  localparam logic signed [GW-1:0]  HALFG = GW'(1) << (GF - 1);

  csbf_pkg::csbf_state_e state_q, state_d;

  logic                          bypass_q;
  logic [3*CW-1:0]               lnum_q, hnum_q;
  logic [2*CW-1:0]               lden_q, hden_q;
  logic [csbf_pkg::GAIN_BITS-1:0] gain_q;

  logic signed [STW-1:0] s1_q [2];
  logic signed [STW-1:0] s2_q [2];

  logic                  stage_q;
  logic                  ok_q;
  logic                  out_valid_q;
  logic signed [SW-1:0]  out_sample_q;
  logic                  out_ovf_q;

  logic signed [DW-1:0]  x_q, ys_q;
  logic signed [PW-1:0]  prod_q, acc_q;
  logic signed [NW-1:0]  n1_q;

  logic [3*CW-1:0]       num_w;
  logic [2*CW-1:0]       den_w;
  logic signed [KW-1:0]  coef_op;
  logic signed [DW-1:0]  data_op;
  logic signed [PW-1:0]  mul_w;
  logic signed [EW-1:0]  al_in;
  logic signed [STW-1:0] addend;
  logic signed [TW1-1:0] t1_w;
  logic signed [AW-1:0]  al1_w;
  logic signed [NW-1:0]  sum_w;
  logic signed [NW:0]    t2_w;
  logic signed [DW-1:0]  ys_w;
  logic signed [GW-1:0]  gt_w;
  logic                  fits_sum, fits_n1, gain_ovf;
  logic                  in_accept, out_load, res_ovf, cfg_we, bypass_flip;
  logic signed [SW-1:0]  res_sample;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign bypass_flip = cfg_we && (cfg_index_i == csbf_pkg::REG_BYPASS) &&
                       (cfg_data_i[0] != bypass_q);

  assign in_stall_o  = (state_q != csbf_pkg::ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;

  assign num_w = stage_q ? hnum_q : lnum_q;
  assign den_w = stage_q ? hden_q : lden_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csbf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bypass_q ? csbf_pkg::ST_OUT : csbf_pkg::ST_B0;
      end
      csbf_pkg::ST_B0:   state_d = csbf_pkg::ST_B1;
      csbf_pkg::ST_B1:   state_d = csbf_pkg::ST_A1;
      csbf_pkg::ST_A1:   state_d = csbf_pkg::ST_B2;
      csbf_pkg::ST_B2:   state_d = csbf_pkg::ST_A2;
      csbf_pkg::ST_A2:   state_d = csbf_pkg::ST_FIN;
      csbf_pkg::ST_FIN:  state_d = stage_q ? csbf_pkg::ST_GAIN : csbf_pkg::ST_B0;
      csbf_pkg::ST_GAIN: state_d = csbf_pkg::ST_OUT;
      csbf_pkg::ST_OUT: begin
        if (out_load) state_d = csbf_pkg::ST_IDLE;
      end
      default:           state_d = csbf_pkg::ST_IDLE;
    endcase
  end

  // operand selection per step
  always_comb begin
    coef_op = '0;
    data_op = x_q;
    al_in   = EW'(acc_q) - EW'(prod_q);
    addend  = '0;
    unique case (state_q)
      csbf_pkg::ST_B0: coef_op = KW'(signed'(num_w[CW-1:0]));
      csbf_pkg::ST_B1: begin
        coef_op = KW'(signed'(num_w[2*CW-1:CW]));
        al_in   = EW'(prod_q);
        addend  = s1_q[stage_q];
      end
      csbf_pkg::ST_A1: begin
        coef_op = KW'(signed'(den_w[CW-1:0]));
        data_op = ys_q;
      end
      csbf_pkg::ST_B2: begin
        coef_op = KW'(signed'(num_w[3*CW-1:2*CW]));
        addend  = s2_q[stage_q];
      end
      csbf_pkg::ST_A2: begin
        coef_op = KW'(signed'(den_w[2*CW-1:CW]));
        data_op = ys_q;
      end
      csbf_pkg::ST_GAIN: coef_op = KW'(signed'({1'b0, gain_q}));
      default: ;
    endcase
  end

  assign out_load = (state_q == csbf_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // shared multiplier and alignment adders
  assign mul_w  = coef_op * data_op;
  assign t1_w   = TW1'(al_in) + HALF1;
  assign al1_w  = AW'(t1_w >>> RS1) <<< LS1;
  assign sum_w  = NW'(al1_w) + NW'(addend);
  assign t2_w   = (NW + 1)'(sum_w) + HALF2;
  assign ys_w   = DW'(t2_w >>> RS2) <<< LS2;
  assign gt_w   = GW'(prod_q) + HALFG;

  assign fits_sum = (&sum_w[NW-1:STW-1]) | ~(|sum_w[NW-1:STW-1]);
  assign fits_n1  = (&n1_q[NW-1:STW-1])  | ~(|n1_q[NW-1:STW-1]);
  assign gain_ovf = ~((&gt_w[GW-1:SW+GF-1]) | ~(|gt_w[GW-1:SW+GF-1]));

  assign res_ovf    = ~bypass_q & (~ok_q | gain_ovf);
  assign res_sample = bypass_q ? x_q[SW-1:0] : (res_ovf ? '0 : gt_w[SW+GF-1:GF]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      lnum_q   <= '0;
      lden_q   <= '0;
      hnum_q   <= '0;
      hden_q   <= '0;
      gain_q   <= csbf_pkg::GAIN_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        csbf_pkg::REG_BYPASS:      bypass_q <= cfg_data_i[0];
        csbf_pkg::REG_LOW_NUM:     lnum_q   <= cfg_data_i;
        csbf_pkg::REG_LOW_DEN:     lden_q   <= cfg_data_i[2*CW-1:0];
        csbf_pkg::REG_HIGH_NUM:    hnum_q   <= cfg_data_i;
        csbf_pkg::REG_HIGH_DEN:    hden_q   <= cfg_data_i[2*CW-1:0];
        csbf_pkg::REG_OUTPUT_GAIN: gain_q   <= cfg_data_i[csbf_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // filter state words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '{default: '0};
      s2_q <= '{default: '0};
    end else if (bypass_flip || (out_load && res_ovf)) begin
      s1_q <= '{default: '0};
      s2_q <= '{default: '0};
    end else if (state_q == csbf_pkg::ST_FIN) begin
      s1_q[stage_q] <= n1_q[STW-1:0];
      s2_q[stage_q] <= sum_w[STW-1:0];
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csbf_pkg::ST_IDLE;
      stage_q     <= 1'b0;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        stage_q <= 1'b0;
        ok_q    <= 1'b1;
      end else if (state_q == csbf_pkg::ST_FIN) begin
        stage_q <= 1'b1;
        ok_q    <= ok_q & fits_n1 & fits_sum;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    // gain product is held while the result waits for the output register
    if (state_q != csbf_pkg::ST_OUT) prod_q <= mul_w;
    if (in_accept) x_q <= DW'(sample_in_i);
    unique case (state_q)
      csbf_pkg::ST_B1:  ys_q  <= ys_w;
      csbf_pkg::ST_A1:  acc_q <= prod_q;
      csbf_pkg::ST_B2:  n1_q  <= sum_w;
      csbf_pkg::ST_A2:  acc_q <= prod_q;
      csbf_pkg::ST_FIN: x_q   <= ys_q;
      default: ;
    endcase
    if (out_load) begin
      out_sample_q <= res_sample;
      out_ovf_q    <= res_ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_out_o     = out_sample_q;
  assign overflow_reset_o = out_ovf_q;

endmodule

>>> hw/rtl/csbf_checker.sv
// port-level checks for the cascaded shelf biquad filter
// bound to cascaded_shelf_biquad_filter; no package dependency

module csbf_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                    overflow_reset_o
);

  // a held result keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an overflow result always carries a zero sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_reset_o |-> sample_out_o == '0)
    else $error("overflow result with nonzero sample");

  // one item at a time: input stalls right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // a new result only appears from a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

endmodule

bind cascaded_shelf_biquad_filter csbf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_csbf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .sample_out_o     (sample_out_o),
  .overflow_reset_o (overflow_reset_o)
);

>>> test/tb_cascaded_shelf_biquad_filter.sv
// testbench for cascaded_shelf_biquad_filter: directed and random samples checked against a
// fixed-point prediction of both shelf sections, with random idling on both item channels
// depends on csbf_pkg and the filter top level
`timescale 1ns / 1ps

module tb_cascaded_shelf_biquad_filter;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 20;
  localparam int STATE_W = 40;
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;
  localparam int COEF_FRAC = COEF_W - 3;
  localparam int STATE_FRAC = STATE_W - 9;
  localparam int PROD_FRAC = SAMPLE_FRAC + COEF_FRAC;
  localparam int COEF_ONE = 1 << COEF_FRAC;
  localparam logic [csbf_pkg::GAIN_BITS-1:0] GAIN_MAX = '1;
  localparam logic [csbf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [csbf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       overflow;
  } filter_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [csbf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [3*COEF_W-1:0]           cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_W-1:0]    sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample_out_o;
  logic                          overflow_reset_o;

  cascaded_shelf_biquad_filter dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted filter configuration and state
  bit                 bypass_on = 1'b1;
  logic [59:0]        low_num = '0;
  logic [39:0]        low_den = '0;
  logic [59:0]        high_num = '0;
  logic [39:0]        high_den = '0;
  logic [csbf_pkg::GAIN_BITS-1:0] out_gain = csbf_pkg::GAIN_UNITY;
  longint             low_s1 = 0, low_s2 = 0, high_s1 = 0, high_s2 = 0;

  filter_result_t     pending_outputs[$];
  filter_result_t     want;
  int                 mismatch_count = 0;
  int unsigned        out_hold = 0;
  bit                 burst_mode = 1'b0;

  function automatic longint coef_at(input logic [59:0] coefs, input int slot);
    logic [59:0] t;
    t = coefs >> (slot * COEF_W);
    return longint'($signed(t[COEF_W-1:0]));
  endfunction

  function automatic longint rescale(input longint v, input int from_frac, input int to_frac);
    int d;
    if (from_frac > to_frac) begin
      d = from_frac - to_frac;
      return (v + (longint'(1) <<< (d - 1))) >>> d;
    end
    return v <<< (to_frac - from_frac);
  endfunction

  function automatic bit fits_signed(input longint v, input int w);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    return (v >= -lim) && (v < lim);
  endfunction

  function automatic bit run_section(input longint x, input logic [59:0] num,
                                     input logic [59:0] den, inout longint s1,
                                     inout longint s2, output longint yo);
    longint y, ys, n1, n2;
    y = rescale(coef_at(num, 0) * x, PROD_FRAC, STATE_FRAC) + s1;
    ys = rescale(y, STATE_FRAC, SAMPLE_FRAC);
    n1 = rescale(coef_at(num, 1) * x - coef_at(den, 0) * ys, PROD_FRAC, STATE_FRAC) + s2;
    n2 = rescale(coef_at(num, 2) * x - coef_at(den, 1) * ys, PROD_FRAC, STATE_FRAC);
    s1 = n1;
    s2 = n2;
    yo = ys;
    return fits_signed(n1, STATE_W) && fits_signed(n2, STATE_W);
  endfunction

  function automatic void clear_filter_state();
    low_s1 = 0;
    low_s2 = 0;
    high_s1 = 0;
    high_s2 = 0;
  endfunction

  function automatic filter_result_t predict_filter_output(input logic signed [SAMPLE_W-1:0] x);
    filter_result_t r;
    longint y1, y2, scaled;
    bit ok_low, ok_high;
    if (bypass_on) begin
      r.sample = x;
      r.overflow = 1'b0;
      return r;
    end
    ok_low = run_section(longint'(x), low_num, {20'd0, low_den}, low_s1, low_s2, y1);
    ok_high = run_section(y1, high_num, {20'd0, high_den}, high_s1, high_s2, y2);
    scaled = rescale(y2 * longint'({1'b0, out_gain}), SAMPLE_FRAC + csbf_pkg::GAIN_FRAC,
                     SAMPLE_FRAC);
    if (!ok_low || !ok_high || !fits_signed(scaled, SAMPLE_W)) begin
      clear_filter_state();
      r.sample = '0;
      r.overflow = 1'b1;
    end else begin
      r.sample = scaled[SAMPLE_W-1:0];
      r.overflow = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [59:0] random_bits60();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[59:0];
  endfunction

  function automatic logic [59:0] pack_coefs(input int c0, input int c1, input int c2);
    return {c2[COEF_W-1:0], c1[COEF_W-1:0], c0[COEF_W-1:0]};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3, 4: return SAMPLE_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [csbf_pkg::CFG_IDX_W-1:0] idx, input logic [59:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      csbf_pkg::REG_BYPASS: begin
        if (data[0] != bypass_on) clear_filter_state();
        bypass_on = data[0];
      end
      csbf_pkg::REG_LOW_NUM: low_num = data;
      csbf_pkg::REG_LOW_DEN: low_den = data[39:0];
      csbf_pkg::REG_HIGH_NUM: high_num = data;
      csbf_pkg::REG_HIGH_DEN: high_den = data[39:0];
      csbf_pkg::REG_OUTPUT_GAIN: out_gain = data[csbf_pkg::GAIN_BITS-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    pending_outputs.push_back(predict_filter_output(x));
  endtask

  task automatic wait_outputs_drained();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_stable_shelf(input logic [csbf_pkg::CFG_IDX_W-1:0] num_reg,
                                   input logic [csbf_pkg::CFG_IDX_W-1:0] den_reg);
    int a1, a2, lim;
    a2 = int'($urandom_range(0, 2 * 117964)) - 117964;
    lim = ((COEF_ONE + a2) * 95) / 100;
    a1 = int'($urandom_range(0, 2 * lim)) - lim;
    write_reg(num_reg, pack_coefs(int'($urandom_range(COEF_ONE / 2, COEF_ONE * 3 / 2)),
                                  int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE,
                                  int'($urandom_range(0, COEF_ONE)) - COEF_ONE / 2));
    write_reg(den_reg, pack_coefs(a1, a2, 0));
  endtask

  task automatic test_bypass_and_spare_registers();
    write_reg(REG_SPARE_LO, random_bits60());
    write_reg(REG_SPARE_HI, '1);
    write_reg(csbf_pkg::REG_BYPASS, 60'd1);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('1);
    wait_outputs_drained();
  endtask

  task automatic test_unity_passthrough();
    write_reg(csbf_pkg::REG_LOW_NUM, pack_coefs(COEF_ONE, 0, 0));
    write_reg(csbf_pkg::REG_HIGH_NUM, pack_coefs(COEF_ONE, 0, 0));
    write_reg(csbf_pkg::REG_LOW_DEN, '0);
    write_reg(csbf_pkg::REG_HIGH_DEN, '0);
    write_reg(csbf_pkg::REG_OUTPUT_GAIN, 60'(csbf_pkg::GAIN_UNITY));
    write_reg(csbf_pkg::REG_BYPASS, '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(24'h555555);
    wait_outputs_drained();
  endtask

  task automatic test_gain_extremes();
    write_reg(csbf_pkg::REG_OUTPUT_GAIN, '0);
    send_sample(SAMPLE_MAX);
    wait_outputs_drained();
    // gain above unity, output leaves range at full scale
    write_reg(csbf_pkg::REG_OUTPUT_GAIN, 60'(GAIN_MAX));
    send_sample(24'h400000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    wait_outputs_drained();
    write_reg(csbf_pkg::REG_OUTPUT_GAIN, 60'(csbf_pkg::GAIN_UNITY));
  endtask

  task automatic test_state_blowup();
    write_reg(csbf_pkg::REG_LOW_NUM,
              pack_coefs(COEF_ONE * 4 - 1, COEF_ONE * 4 - 1, COEF_ONE * 4 - 1));
    write_reg(csbf_pkg::REG_LOW_DEN, pack_coefs(-COEF_ONE * 4, -COEF_ONE * 4, 0));
    repeat (6) send_sample(SAMPLE_MAX);
    wait_outputs_drained();
  endtask

  task automatic test_bypass_toggle();
    write_reg(csbf_pkg::REG_BYPASS, 60'd1);
    send_sample(24'h123456);
    send_sample(SAMPLE_MIN);
    wait_outputs_drained();
    write_reg(csbf_pkg::REG_BYPASS, '0);
    send_sample(24'h200000);
    send_sample(24'hE00000);
    wait_outputs_drained();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      burst_mode = (phase % 4 == 3);
      case (phase % 6)
        3: begin
          write_reg(csbf_pkg::REG_LOW_NUM, random_bits60());
          write_reg(csbf_pkg::REG_LOW_DEN, random_bits60());
          write_reg(csbf_pkg::REG_HIGH_NUM, random_bits60());
          write_reg(csbf_pkg::REG_HIGH_DEN, random_bits60());
          write_reg(csbf_pkg::REG_OUTPUT_GAIN, random_bits60());
          write_reg(REG_SPARE_LO, random_bits60());
          write_reg(csbf_pkg::REG_BYPASS, random_bits60() & ~60'd1);
        end
        4: begin
          load_stable_shelf(csbf_pkg::REG_LOW_NUM, csbf_pkg::REG_LOW_DEN);
          load_stable_shelf(csbf_pkg::REG_HIGH_NUM, csbf_pkg::REG_HIGH_DEN);
          write_reg(csbf_pkg::REG_OUTPUT_GAIN,
                    $urandom_range(0, 1) ? 60'(GAIN_MAX) : 60'(csbf_pkg::GAIN_UNITY));
          write_reg(csbf_pkg::REG_BYPASS, '0);
        end
        5: begin
          write_reg(csbf_pkg::REG_LOW_NUM, random_bits60());
          write_reg(csbf_pkg::REG_BYPASS, random_bits60() | 60'd1);
        end
        default: begin
          load_stable_shelf(csbf_pkg::REG_LOW_NUM, csbf_pkg::REG_LOW_DEN);
          load_stable_shelf(csbf_pkg::REG_HIGH_NUM, csbf_pkg::REG_HIGH_DEN);
          write_reg(csbf_pkg::REG_OUTPUT_GAIN,
                    60'($urandom_range(0, csbf_pkg::GAIN_UNITY)));
          write_reg(csbf_pkg::REG_BYPASS, '0);
        end
      endcase
      for (int n = 0; n < 94; n++) begin
        // hold off until the pipeline has emptied
        if (n == 47) wait_outputs_drained();
        send_sample(draw_sample());
      end
      wait_outputs_drained();
    end
    burst_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected item, sample_out %0d overflow_reset %0b",
                 $time, sample_out_o, overflow_reset_o);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (sample_out_o !== want.sample) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, want.sample, sample_out_o);
          mismatch_count++;
        end
        if (overflow_reset_o !== want.overflow) begin
          $display("%0t: overflow_reset expected %0b actual %0b",
                   $time, want.overflow, overflow_reset_o);
          mismatch_count++;
        end
      end
      out_hold = burst_mode ? 0 : $urandom_range(0, 17);
    end
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bypass_and_spare_registers();
    test_unity_passthrough();
    test_gain_extremes();
    test_state_blowup();
    test_bypass_toggle();
    test_random_settings();
    wait_outputs_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d items outstanding", $time, pending_outputs.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/csbf_pkg.sv
hw/rtl/cascaded_shelf_biquad_filter.sv
hw/rtl/csbf_checker.sv
test/tb_cascaded_shelf_biquad_filter.sv
